### hdl/fixed_point_alu_top_macros.svh
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_TOP_MACROS_SVH
`define FIXED_POINT_ALU_TOP_MACROS_SVH
`ifndef SYNTH
`define FPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpa check failed");
`define FPA_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fpa forbidden condition");
`else
`define FPA_ASSERT_IMP(label, ante, cons)
`define FPA_ASSERT_NEVER(label, cond)
`endif
`endif

### hdl/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
  localparam int FRAC_BITS = 8;
  // numerator width of the divider
  localparam int NW = 32 + FRAC_BITS;
  // input regs, operand stage, NW divide steps, round stage, output stage
  localparam int LATENCY = NW + 4;
  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MIN = 3'd4;
  localparam logic [2:0] OP_MAX = 3'd5;
  localparam logic [2:0] OP_INC = 3'd6;
  localparam logic [2:0] OP_DEC = 3'd7;

  typedef struct packed {
    logic [2:0]    op;
    logic          lt;
    logic          eq;
    logic          gt;
    logic          neg;
    logic          dz;
    logic [31:0]   simple_res;
    logic          simple_ovf;
    logic [31:0]   ma;
    logic [31:0]   mb;
    logic [63:0]   prod;
    logic [31:0]   rem;
    logic [NW-1:0] num;
    logic [NW-1:0] quo;
  } stage_t;
endpackage
`default_nettype wire

### hdl/fixed_point_alu_top.sv
`timescale 1ns / 1ps
`default_nettype none
// signed fixed-point alu, raw 32-bit words with FRAC_BITS fraction bits
// stages: input reg, operand, NW divide steps, round, output (NW = 32 + FRAC_BITS)
// throughput: one word per cycle, busy is never raised
// the restoring divider takes one quotient bit per stage and sets the depth
// reset (synchronous, rst_n low) clears every valid bit; words in flight are lost
// the receiver cannot stall, each result shows for exactly one cycle
`include "fixed_point_alu_top_macros.svh"
module fixed_point_alu_top import fpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic             out_strobe,
  output logic signed [31:0] out_result_value,
  output logic             out_a_less,
  output logic             out_a_equal,
  output logic             out_a_greater,
  output logic             out_divide_by_zero,
  output logic             out_overflowed
);

  // every stage moves on each cycle, nothing holds the pipe
  assign busy = 1'b0;

  // input register
  logic              v0_r;
  logic [2:0]        op0_r;
  logic signed [31:0] a0_r, b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    op0_r <= in_opcode;
    a0_r  <= in_operand_a;
    b0_r  <= in_operand_b;
  end

  // operand stage: flags, short ops, magnitudes
  stage_t             s1_nxt;
  logic signed [32:0] addend;
  logic signed [32:0] sum;
  logic signed [32:0] dif;

  always_comb begin
    s1_nxt     = '0;
    s1_nxt.op  = op0_r;
    s1_nxt.lt  = a0_r < b0_r;
    s1_nxt.eq  = a0_r == b0_r;
    s1_nxt.gt  = a0_r > b0_r;
    s1_nxt.neg = a0_r[31] ^ b0_r[31];
    s1_nxt.dz  = (op0_r == OP_DIV) && (b0_r == 32'sd0);
    s1_nxt.ma  = a0_r[31] ? 32'd0 - a0_r : a0_r;
    s1_nxt.mb  = b0_r[31] ? 32'd0 - b0_r : b0_r;
    s1_nxt.num = NW'(s1_nxt.ma) << FRAC_BITS;
    // inc and dec share the add path with a constant right-hand side
    case (op0_r)
      OP_INC:  addend = 33'sd1;
      OP_DEC:  addend = -33'sd1;
      default: addend = 33'(b0_r);
    endcase
    sum = 33'(a0_r) + addend;
    dif = 33'(a0_r) - 33'(b0_r);
    case (op0_r)
      OP_SUB: begin
        s1_nxt.simple_ovf = dif[32] != dif[31];
        s1_nxt.simple_res = s1_nxt.simple_ovf ?
          (dif[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : dif[31:0];
      end
      OP_MIN:  s1_nxt.simple_res = s1_nxt.lt ? a0_r : b0_r;
      OP_MAX:  s1_nxt.simple_res = s1_nxt.gt ? a0_r : b0_r;
      default: begin
        s1_nxt.simple_ovf = sum[32] != sum[31];
        s1_nxt.simple_res = s1_nxt.simple_ovf ?
          (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];
      end
    endcase
  end

  // stage 1 .. NW+1, each later stage does one restoring divide step
  stage_t          st_r [1:NW+1];
  logic [NW+1:1]   vs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[1] <= 1'b0;
    end else begin
      vs_r[1] <= v0_r;
    end
    st_r[1] <= s1_nxt;
  end

  for (genvar i = 1; i <= NW; i++) begin : g_div
    stage_t      st_nxt;
    logic [32:0] rem_sh;
    always_comb begin
      st_nxt = st_r[i];
      rem_sh = {st_r[i].rem, st_r[i].num[NW-1]};
      st_nxt.num = st_r[i].num << 1;
      if (rem_sh >= {1'b0, st_r[i].mb}) begin
        st_nxt.rem = 32'(rem_sh - {1'b0, st_r[i].mb});
        st_nxt.quo = {st_r[i].quo[NW-2:0], 1'b1};
      end else begin
        st_nxt.rem = rem_sh[31:0];
        st_nxt.quo = {st_r[i].quo[NW-2:0], 1'b0};
      end
      // the product is formed once, right after the operand stage
      if (i == 1) begin
        st_nxt.prod = 64'(st_r[i].ma) * 64'(st_r[i].mb);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[i+1] <= 1'b0;
      end else begin
        vs_r[i+1] <= vs_r[i];
      end
      st_r[i+1] <= st_nxt;
    end
  end

  // round stage: magnitude rounded half away from zero
  stage_t      fin;
  logic        vr_r;
  stage_t      rd_r;
  logic [63:0] mag_nxt, mag_r;

  assign fin = st_r[NW+1];

  always_comb begin
    if (fin.op == OP_DIV) begin
      mag_nxt = 64'(fin.quo) +
                64'({fin.rem, 1'b0} >= {1'b0, fin.mb});
    end else begin
      mag_nxt = (fin.prod + HALF) >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= 1'b0;
    end else begin
      vr_r <= vs_r[NW+1];
    end
    rd_r  <= fin;
    mag_r <= mag_nxt;
  end

  // saturate and select
  logic [31:0] res_nxt;
  logic        ovf_nxt;
  logic        neg_eff;

  always_comb begin
    neg_eff = rd_r.neg && (mag_r != 64'd0);
    res_nxt = rd_r.simple_res;
    ovf_nxt = rd_r.simple_ovf;
    if ((rd_r.op == OP_MUL) || (rd_r.op == OP_DIV)) begin
      if (rd_r.dz) begin
        res_nxt = 32'd0;
        ovf_nxt = 1'b0;
      end else if (neg_eff) begin
        ovf_nxt = mag_r > 64'h8000_0000;
        res_nxt = ovf_nxt ? 32'h8000_0000 : 32'd0 - mag_r[31:0];
      end else begin
        ovf_nxt = mag_r > 64'h7FFF_FFFF;
        res_nxt = ovf_nxt ? 32'h7FFF_FFFF : mag_r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= vr_r;
    end
    out_result_value   <= res_nxt;
    out_a_less         <= rd_r.lt;
    out_a_equal        <= rd_r.eq;
    out_a_greater      <= rd_r.gt;
    out_divide_by_zero <= rd_r.dz;
    out_overflowed     <= ovf_nxt;
  end

  // every result goes back to an earlier start
  `FPA_ASSERT_IMP(a_latency, out_strobe, $past(start, LATENCY))
  // exactly one compare flag on every result
  `FPA_ASSERT_IMP(a_flags, out_strobe, $onehot({out_a_less, out_a_equal, out_a_greater}))
  // a zero divisor gives a clean zero
  `FPA_ASSERT_IMP(a_dz, out_strobe && out_divide_by_zero,
                  out_result_value == 32'sd0 && !out_overflowed)
  `FPA_ASSERT_NEVER(a_busy, busy)

endmodule
`default_nettype wire

### dv/fixed_point_alu_top_test.sv
`timescale 1ns / 1ps
module fixed_point_alu_top_test;
  import fpa_pkg::*;

  // result word as the alu presents it
  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
    logic        ovf;
  } alu_word_t;

  // one directed row: operands, and optionally a hand-typed expectation
  typedef struct {
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    alu_word_t   want;
  } stim_row_t;

  localparam int N_RANDOM = 700;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_opcode;
  logic signed [31:0] in_operand_a;
  logic signed [31:0] in_operand_b;
  logic        out_strobe;
  logic signed [31:0] out_result_value;
  logic        out_a_less;
  logic        out_a_equal;
  logic        out_a_greater;
  logic        out_divide_by_zero;
  logic        out_overflowed;

  alu_word_t   pending_results[$];
  int          n_errors;
  int          n_results;
  int          n_words_sent;
  bit          op_seen[8];

  fixed_point_alu_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .out_strobe         (out_strobe),
    .out_result_value   (out_result_value),
    .out_a_less         (out_a_less),
    .out_a_equal        (out_a_equal),
    .out_a_greater      (out_a_greater),
    .out_divide_by_zero (out_divide_by_zero),
    .out_overflowed     (out_overflowed)
  );

  // free-running clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturate a sign and magnitude into 32 bits
  function automatic logic [31:0] clamp_mag(input bit neg, input logic [63:0] mag,
                                            output bit ovf);
    ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  // saturate a signed 64-bit sum into 32 bits
  function automatic logic [31:0] clamp_sum(input longint s, output bit ovf);
    ovf = 1'b0;
    if (s > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (s < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  // golden arithmetic: what one word of operands should produce
  function automatic alu_word_t alu_compute(input logic [2:0] op, input logic [31:0] a_raw,
                                            input logic [31:0] b_raw);
    longint     a;
    longint     b;
    bit         neg;
    bit         ovf;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] n;
    alu_word_t  w;
    a = longint'(signed'(a_raw));
    b = longint'(signed'(b_raw));
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    ovf = 1'b0;
    w = '0;
    case (op)
      OP_ADD: w.value = clamp_sum(a + b, ovf);
      OP_SUB: w.value = clamp_sum(a - b, ovf);
      OP_MUL: begin
        p = ma * mb;
        r = (p + HALF) >> FRAC_BITS;
        w.value = clamp_mag(neg && r != 0, r, ovf);
      end
      OP_DIV: begin
        if (mb == 0) begin
          w.dz = 1'b1;
          w.value = '0;
        end else begin
          n = ma << FRAC_BITS;
          q = n / mb;
          r = n % mb;
          if (r * 2 >= mb) q = q + 1;
          w.value = clamp_mag(neg && q != 0, q, ovf);
        end
      end
      OP_MIN: w.value = (a < b) ? a_raw : b_raw;
      OP_MAX: w.value = (a > b) ? a_raw : b_raw;
      OP_INC: w.value = clamp_sum(a + 1, ovf);
      default: w.value = clamp_sum(a - 1, ovf);
    endcase
    w.ovf = ovf;
    w.lt = a < b;
    w.eq = a == b;
    w.gt = a > b;
    return w;
  endfunction

  // hand one word to the alu: set up at falling edge, held until accepted
  task automatic send_word(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b,
                           input bit typed, input alu_word_t want);
    alu_word_t golden;
    golden = alu_compute(op, a, b);
    if (typed && golden !== want)
      $error("directed row disagrees with arithmetic: op %0d a %h b %h", op, a, b);
    start <= 1'b1;
    in_opcode <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(typed ? want : golden);
    op_seen[op] = 1'b1;
    n_words_sent++;
    @(negedge clk);
  endtask

  // drop start for a number of cycles
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // random operand, weighted toward the interesting corners
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3: return 32'(signed'($urandom_range(0, 4096)) - 2048);
      4: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    alu_word_t want;
    if (rst_n && out_strobe) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: value %h", out_result_value);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.value) begin
          $error("result_value expected %h actual %h", want.value, out_result_value);
          n_errors++;
        end
        if (out_a_less !== want.lt) begin
          $error("a_less expected %b actual %b", want.lt, out_a_less);
          n_errors++;
        end
        if (out_a_equal !== want.eq) begin
          $error("a_equal expected %b actual %b", want.eq, out_a_equal);
          n_errors++;
        end
        if (out_a_greater !== want.gt) begin
          $error("a_greater expected %b actual %b", want.gt, out_a_greater);
          n_errors++;
        end
        if (out_divide_by_zero !== want.dz) begin
          $error("divide_by_zero expected %b actual %b", want.dz, out_divide_by_zero);
          n_errors++;
        end
        if (out_overflowed !== want.ovf) begin
          $error("overflowed expected %b actual %b", want.ovf, out_overflowed);
          n_errors++;
        end
      end
    end
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("fixed_point_alu_top regression: fail");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    int        burst;
    int        drain;
    int        left;
    logic [2:0] op;
    logic [31:0] a;
    logic [31:0] b;

    // directed table: typed expectations where obvious, otherwise golden
    rows = '{
      '{OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, '{32'h7FFF_FFFF, 0, 0, 1, 0, 1}},
      '{OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 1, 0, 0, 0, 1}},
      '{OP_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1, 0, 0, 0, 1}},
      '{OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 0, 0, 1, 0, 1}},
      '{OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 0, 1, 0, 0, 1}},
      '{OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, 1, 0, 0, 0, 1}},
      '{OP_MUL, 32'h0000_0001, 32'h0000_0080, 1'b0, '0},   // tie rounds away from zero
      '{OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 1'b0, '0},   // negative tie
      '{OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0},   // rounds to zero, no negative zero
      '{OP_DIV, 32'h1234_5678, 32'h0000_0000, 1'b1, '{32'h0000_0000, 0, 0, 1, 1, 0}},
      '{OP_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 0, 1, 0, 1, 0}},
      '{OP_DIV, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1, 0, 0, 0, 1}},
      '{OP_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 0, 0, 1, 0, 1}},
      '{OP_DIV, 32'h0000_0001, 32'h0000_0200, 1'b0, '0},   // half quotient tie
      '{OP_DIV, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, 1, 0, 0, 0, 0}},
      '{OP_MIN, 32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0000_0005, 0, 1, 0, 0, 0}},
      '{OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1, 0, 0, 0, 0}},
      '{OP_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
      '{OP_INC, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 0, 0, 1, 0, 1}},
      '{OP_INC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 0, 1, 0, 0, 0}},
      '{OP_DEC, 32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h8000_0000, 1, 0, 0, 0, 1}},
      '{OP_DEC, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 0, 0, 1, 0, 0}},
      '{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_SUB, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };

    n_errors = 0;
    n_results = 0;
    n_words_sent = 0;
    start = 1'b0;
    in_opcode = OP_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words back to back
    foreach (rows[i])
      send_word(rows[i].op, rows[i].a, rows[i].b, rows[i].typed, rows[i].want);

    // hold off until the pipe has fully drained at least once
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    // random part: bursts of random length, random gaps, some long unbroken runs
    left = N_RANDOM;
    while (left > 0) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) begin
        op = 3'($urandom_range(0, 7));
        a = pick_operand();
        b = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1)) ? a : 32'h0) : pick_operand();
        send_word(op, a, b, 1'b0, '0);
      end
      left -= burst;
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 60));
    end
    start <= 1'b0;

    // drain, bounded
    drain = 0;
    while (pending_results.size() != 0 && drain < 20 * LATENCY) begin
      @(negedge clk);
      drain++;
    end
    repeat (LATENCY + 4) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      n_errors++;
    end

    $display("sent %0d words (%0d directed), checked %0d results", n_words_sent,
             rows.size(), n_results);
    $display("opcodes exercised: add %0b sub %0b mul %0b div %0b min %0b max %0b inc %0b dec %0b",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6], op_seen[7]);
    if (n_errors == 0)
      $display("fixed_point_alu_top regression: pass");
    else
      $display("fixed_point_alu_top regression: fail");
    $finish;
  end
endmodule
